### rtl/dnsrt_pkg.sv
// Shared types and constants of the DNS response time binner.
// No dependencies; imported by dnsrt_front, dnsrt_binner and the core.
package dnsrt_pkg;

	localparam int CAPACITY   = 1024;
	localparam int CAP_W      = $clog2(CAPACITY);
	localparam int SLOT_W     = CAP_W + 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int FIFO_DEPTH = 2;
	localparam int IDX_W      = 26;
	localparam int KEY_W      = 57;
	localparam int TIME_W     = 52;
	localparam int US_PER_SEC = 1000000;

	localparam logic [SLOT_W-1:0] EMPTY_SLOT = SLOT_W'(CAPACITY);

	localparam logic [IDX_W-1:0] IDX_TIMEOUT = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_MISSING = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_DROPPED = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_ERROR   = IDX_W'(3);
	localparam logic [IDX_W-1:0] FIRST_BIN   = IDX_W'(4);

	localparam logic [1:0] BIN_LINEAR = 2'd0;
	localparam logic [1:0] BIN_LOG10  = 2'd1;
	localparam logic [1:0] BIN_LOG2   = 2'd2;

	localparam logic [2:0] REG_BIN_MODE    = 3'd0;
	localparam logic [2:0] REG_MAX_SECONDS = 3'd1;
	localparam logic [2:0] REG_OVER_LIMIT  = 3'd2;
	localparam logic [2:0] REG_BUCKET_W    = 3'd3;
	localparam logic [2:0] REG_MAX_PENDING = 3'd4;
	localparam logic [2:0] REG_FULL_MODE   = 3'd5;

	localparam int N_POW10 = 7;
	localparam logic [IDX_W-1:0] POW10 [N_POW10] = '{
		IDX_W'(10), IDX_W'(100), IDX_W'(1000), IDX_W'(10000),
		IDX_W'(100000), IDX_W'(1000000), IDX_W'(10000000)
	};

	typedef struct packed {
		logic              is_response;
		logic [KEY_W-1:0]  key;
		logic [63:0]       chi;
		logic [63:0]       clo;
		logic [63:0]       shi;
		logic [63:0]       slo;
		logic [31:0]       tsec;
		logic [19:0]       tusec;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [63:0]       chi;
		logic [63:0]       clo;
		logic [63:0]       shi;
		logic [63:0]       slo;
	} tag_t;

endpackage

### rtl/dnsrt_if.sv
// Channel interfaces of the binner: message input, result output, register writes.
// Plain widths of the message fields; no package needed.
interface dnsrt_req_if;
	logic        valid;
	logic        ready;
	logic        is_response;
	logic [15:0] dns_id;
	logic        ip_version6;
	logic [7:0]  protocol;
	logic [63:0] client_addr_hi;
	logic [63:0] client_addr_lo;
	logic [15:0] client_port;
	logic [63:0] server_addr_hi;
	logic [63:0] server_addr_lo;
	logic [15:0] server_port;
	logic [31:0] time_sec;
	logic [19:0] time_usec;
	modport source(output valid, is_response, dns_id, ip_version6, protocol, client_addr_hi,
		client_addr_lo, client_port, server_addr_hi, server_addr_lo, server_port,
		time_sec, time_usec, input ready);
	modport sink(input valid, is_response, dns_id, ip_version6, protocol, client_addr_hi,
		client_addr_lo, client_port, server_addr_hi, server_addr_lo, server_port,
		time_sec, time_usec, output ready);
endinterface

interface dnsrt_rsp_if;
	logic        valid;
	logic        ready;
	logic        has_index;
	logic [25:0] index;
	logic [25:0] max_index_seen;
	modport source(output valid, has_index, index, max_index_seen, input ready);
	modport sink(input valid, has_index, index, max_index_seen, output ready);
endinterface

interface dnsrt_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  reg_index;
	logic [19:0] wdata;
	modport source(output valid, reg_index, wdata, input ready);
	modport sink(input valid, reg_index, wdata, output ready);
endinterface

### rtl/dnsrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dnsrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/dnsrt_front.sv
// Front end: accepts message beats, packs the lookup key and queues items.
// Depends on dnsrt_pkg and dnsrt_req_if.
module dnsrt_front import dnsrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dnsrt_req_if.sink   req,
	input  logic        hold,
	input  logic        pop,
	output logic        item_vld,
	output item_t       item
);

	localparam int FA_W = $clog2(FIFO_DEPTH);
	localparam int FC_W = $clog2(FIFO_DEPTH + 1);

	item_t            fifo_q [FIFO_DEPTH];
	logic [FA_W-1:0]  wr_ptr_q;
	logic [FA_W-1:0]  rd_ptr_q;
	logic [FC_W-1:0]  count_q;
	item_t            in_item;
	logic             push;
	logic             pull;

	always_comb begin
		in_item.is_response = req.is_response;
		in_item.key         = {req.server_port, req.client_port, req.protocol,
			req.ip_version6, req.dns_id};
		in_item.chi         = req.client_addr_hi;
		in_item.clo         = req.client_addr_lo;
		in_item.shi         = req.server_addr_hi;
		in_item.slo         = req.server_addr_lo;
		in_item.tsec        = req.time_sec;
		in_item.tusec       = req.time_usec;
	end

	assign req.ready = !hold && (count_q != FC_W'(FIFO_DEPTH));
	assign push      = req.valid && req.ready;
	assign item_vld  = count_q != '0;
	assign item      = fifo_q[rd_ptr_q];
	assign pull      = pop && item_vld;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FA_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pull) begin
				rd_ptr_q <= (rd_ptr_q == FA_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FC_W'(push) - FC_W'(pull);
		end
	end

endmodule

### rtl/dnsrt_binner.sv
// Elapsed-time unit: normalises the time difference, applies the age limit and
// bins the microseconds (serial divide, log10 table or log2). Depends on dnsrt_pkg.
module dnsrt_binner import dnsrt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] qtime,
	input  logic [31:0]       now_sec,
	input  logic [19:0]       now_usec,
	input  logic [5:0]        max_seconds,
	input  logic              over_limit_mode,
	input  logic [1:0]        bin_mode,
	input  logic [19:0]       bucket_width_us,
	output logic              done,
	output logic [IDX_W-1:0]  idx
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_NORM = 3'd1;
	localparam logic [2:0] B_MUL  = 3'd2;
	localparam logic [2:0] B_SEL  = 3'd3;
	localparam logic [2:0] B_DIV  = 3'd4;

	logic [2:0]          state_q;
	logic signed [33:0]  ds_s1;
	logic signed [21:0]  du_s1;
	logic                err_s2;
	logic                tmo_s2;
	logic [5:0]          sec_s2;
	logic [19:0]         usec_s2;
	logic [IDX_W-1:0]    us_s3;
	logic [19:0]         rem_q;
	logic [IDX_W-1:0]    quo_q;
	logic [4:0]          cnt_q;

	logic signed [33:0]  ds_n;
	logic signed [21:0]  du_n;
	logic                over;
	logic [19:0]         wid;
	logic [20:0]         rem_sh;
	logic [19:0]         rem_nx;
	logic [IDX_W-1:0]    quo_nx;
	logic [2:0]          n10;
	logic [4:0]          n2;

	// One normalising step of the microseconds.
	always_comb begin
		ds_n = ds_s1;
		du_n = du_s1;
		if (du_s1 >= 22'sd1000000) begin
			ds_n = ds_s1 + 34'sd1;
			du_n = du_s1 - 22'sd1000000;
		end else if (du_s1 < 22'sd0) begin
			ds_n = ds_s1 - 34'sd1;
			du_n = du_s1 + 22'sd1000000;
		end
		over = ds_n >= $signed({28'b0, max_seconds});
	end

	always_comb begin
		wid    = (bucket_width_us == '0) ? 20'd1 : bucket_width_us;
		rem_sh = {rem_q, quo_q[IDX_W-1]};
		if (rem_sh >= {1'b0, wid}) begin
			rem_nx = 20'(rem_sh - {1'b0, wid});
			quo_nx = {quo_q[IDX_W-2:0], 1'b1};
		end else begin
			rem_nx = rem_sh[19:0];
			quo_nx = {quo_q[IDX_W-2:0], 1'b0};
		end
	end

	always_comb begin
		n10 = '0;
		for (int i = 0; i < N_POW10; i++) begin
			n10 = n10 + 3'(us_s3 >= POW10[i]);
		end
		n2 = '0;
		for (int i = 1; i < IDX_W; i++) begin
			if (us_s3[i]) begin
				n2 = 5'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ds_s1 <= {2'b0, now_sec} - {2'b0, qtime[TIME_W-1:20]};
				du_s1 <= {2'b0, now_usec} - {2'b0, qtime[19:0]};
			end
			B_NORM: begin
				err_s2 <= (ds_n < 34'sd0) || (du_n < 22'sd0);
				tmo_s2 <= over && over_limit_mode;
				sec_s2 <= over ? max_seconds : ds_n[5:0];
				usec_s2 <= over ? 20'd0 : du_n[19:0];
			end
			B_MUL: begin
				us_s3 <= 26'(26'(sec_s2) * 26'(US_PER_SEC)) + 26'(usec_s2);
			end
			B_SEL: begin
				rem_q <= '0;
				quo_q <= us_s3;
			end
			B_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done    <= 1'b0;
			idx     <= '0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (start) begin
						state_q <= B_NORM;
					end
				end
				B_NORM: state_q <= B_MUL;
				B_MUL:  state_q <= B_SEL;
				B_SEL: begin
					state_q <= B_IDLE;
					done    <= 1'b1;
					if (err_s2) begin
						idx <= IDX_ERROR;
					end else if (tmo_s2) begin
						idx <= IDX_TIMEOUT;
					end else begin
						case (bin_mode)
							BIN_LINEAR: begin
								done    <= 1'b0;
								cnt_q   <= '0;
								state_q <= B_DIV;
							end
							BIN_LOG10: idx <= (us_s3 == '0) ? IDX_ERROR : FIRST_BIN + IDX_W'(n10);
							BIN_LOG2:  idx <= (us_s3 == '0) ? IDX_ERROR : FIRST_BIN + IDX_W'(n2);
							default:   idx <= IDX_ERROR;
						endcase
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(IDX_W - 1)) begin
						idx     <= FIRST_BIN + quo_nx;
						done    <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

### rtl/dns_response_time_binner_core.sv
// Flow: a message takes one full scan of the tag RAM (one read port, one entry a cycle)
// before its decision; a linear-bin response adds the serial divide. One message is
// worked at a time; two more wait in the front queue.
// Reset: a clearing pass over all CAPACITY entries empties the table; no message is taken
// until it ends, register writes are taken throughout.
module dns_response_time_binner_core import dnsrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dnsrt_req_if.sink   req,
	dnsrt_rsp_if.source rsp,
	dnsrt_cfg_if.sink   cfg
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_EV    = 4'd4;
	localparam logic [3:0] S_UNL   = 4'd5;
	localparam logic [3:0] S_APP1  = 4'd6;
	localparam logic [3:0] S_APP2  = 4'd7;
	localparam logic [3:0] S_BIN   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;
	localparam int TAG_W = $bits(tag_t);

	// configuration
	logic [1:0]  bin_mode_q;
	logic [5:0]  max_seconds_q;
	logic        over_limit_q;
	logic [19:0] bucket_w_q;
	logic [10:0] max_pending_q;
	logic        full_mode_q;

	logic [3:0]        state_q;
	item_t             item_q;
	item_t             fr_item;
	logic              fr_vld;
	logic [SLOT_W-1:0] scan_addr_q;
	logic              rd_vld_s1;
	logic [CAP_W-1:0]  rd_addr_s1;
	logic              match_vld_q;
	logic [CAP_W-1:0]  match_q;
	logic              free_vld_q;
	logic [CAP_W-1:0]  free_q;
	logic [CAP_W-1:0]  tgt_q;
	logic [CAP_W-1:0]  o_q;
	logic [CAP_W-1:0]  n_q;
	logic [TIME_W-1:0] qtime_q;
	logic              do_app_q;
	logic              do_bin_q;
	logic              bin_go_q;
	logic              res_has_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [SLOT_W-1:0] newest_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  highest_q;
	logic              out_vld_q;
	logic              out_has_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [IDX_W-1:0]  out_max_q;

	// RAM ports
	logic              tag_we;
	logic [CAP_W-1:0]  tag_waddr;
	tag_t              tag_wdata;
	tag_t              tag_rd;
	logic              time_we;
	logic [TIME_W-1:0] time_rd;
	logic              old_we;
	logic [CAP_W-1:0]  old_waddr;
	logic [CAP_W-1:0]  old_wdata;
	logic [CAP_W-1:0]  old_rd;
	logic              new_we;
	logic [CAP_W-1:0]  new_waddr;
	logic [CAP_W-1:0]  new_wdata;
	logic [CAP_W-1:0]  new_rd;
	logic [CAP_W-1:0]  rd_slot;
	tag_t              item_tag;

	// decisions and list fix-up
	logic              hit;
	logic [31:0]       limit;
	logic              full;
	logic signed [33:0] age;
	logic              young;
	logic [SLOT_W-1:0] s_ext;
	logic              s_old;
	logic              s_new;
	logic [SLOT_W-1:0] nold;
	logic [SLOT_W-1:0] nnew_t;
	logic [SLOT_W-1:0] nnew;
	logic              bin_done;
	logic [IDX_W-1:0]  bin_idx;
	logic              out_load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_mode_q    <= BIN_LOG10;
			max_seconds_q <= 6'd5;
			over_limit_q  <= 1'b0;
			bucket_w_q    <= 20'd100;
			max_pending_q <= 11'd1024;
			full_mode_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_BIN_MODE:    bin_mode_q    <= cfg.wdata[1:0];
				REG_MAX_SECONDS: max_seconds_q <= cfg.wdata[5:0];
				REG_OVER_LIMIT:  over_limit_q  <= cfg.wdata[0];
				REG_BUCKET_W:    bucket_w_q    <= cfg.wdata;
				REG_MAX_PENDING: max_pending_q <= cfg.wdata[10:0];
				REG_FULL_MODE:   full_mode_q   <= cfg.wdata[0];
				default: begin
				end
			endcase
		end
	end

	dnsrt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.hold     (state_q == S_CLEAR),
		.pop      (state_q == S_IDLE),
		.item_vld (fr_vld),
		.item     (fr_item)
	);

	dnsrt_ram #(.WIDTH(TAG_W), .DEPTH(CAPACITY)) u_tag_ram (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.raddr(scan_addr_q[CAP_W-1:0]), .rdata(tag_rd)
	);

	dnsrt_ram #(.WIDTH(TIME_W), .DEPTH(CAPACITY)) u_time_ram (
		.clk(clk), .we(time_we), .waddr(tgt_q), .wdata({item_q.tsec, item_q.tusec}),
		.raddr(rd_slot), .rdata(time_rd)
	);

	dnsrt_ram #(.WIDTH(CAP_W), .DEPTH(CAPACITY)) u_older_ram (
		.clk(clk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
		.raddr(rd_slot), .rdata(old_rd)
	);

	dnsrt_ram #(.WIDTH(CAP_W), .DEPTH(CAPACITY)) u_newer_ram (
		.clk(clk), .we(new_we), .waddr(new_waddr), .wdata(new_wdata),
		.raddr(rd_slot), .rdata(new_rd)
	);

	dnsrt_binner u_binner (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (bin_go_q),
		.qtime           (qtime_q),
		.now_sec         (item_q.tsec),
		.now_usec        (item_q.tusec),
		.max_seconds     (max_seconds_q),
		.over_limit_mode (over_limit_q),
		.bin_mode        (bin_mode_q),
		.bucket_width_us (bucket_w_q),
		.done            (bin_done),
		.idx             (bin_idx)
	);

	always_comb begin
		item_tag.valid = 1'b1;
		item_tag.key   = item_q.key;
		item_tag.chi   = item_q.chi;
		item_tag.clo   = item_q.clo;
		item_tag.shi   = item_q.shi;
		item_tag.slo   = item_q.slo;
		hit = tag_rd.valid && (tag_rd.key == item_q.key) && (tag_rd.chi == item_q.chi) &&
			(tag_rd.clo == item_q.clo) && (tag_rd.shi == item_q.shi) &&
			(tag_rd.slo == item_q.slo);
		rd_slot = match_vld_q ? match_q : oldest_q[CAP_W-1:0];

		if (max_pending_q == '0) begin
			limit = 32'd1;
		end else if ({21'b0, max_pending_q} > 32'(CAPACITY)) begin
			limit = 32'(CAPACITY);
		end else begin
			limit = {21'b0, max_pending_q};
		end
		full  = (32'(count_q) >= limit) && (oldest_q != EMPTY_SLOT);
		age   = {2'b0, item_q.tsec} - {2'b0, time_rd[TIME_W-1:20]};
		young = age < $signed({28'b0, max_seconds_q});

		// unlink of tgt_q, with the sole-entry case emptying both ends
		s_ext  = {1'b0, tgt_q};
		s_old  = s_ext == oldest_q;
		s_new  = s_ext == newest_q;
		nold   = s_old ? (s_new ? EMPTY_SLOT : {1'b0, n_q}) : oldest_q;
		nnew_t = s_new ? (((s_ext == nold) || (nold == EMPTY_SLOT)) ? EMPTY_SLOT : {1'b0, o_q})
			: newest_q;
		nnew   = (nold == EMPTY_SLOT) ? EMPTY_SLOT : nnew_t;
	end

	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = tgt_q;
		tag_wdata = '0;
		time_we   = 1'b0;
		old_we    = 1'b0;
		old_waddr = tgt_q;
		old_wdata = tgt_q;
		new_we    = 1'b0;
		new_waddr = tgt_q;
		new_wdata = tgt_q;
		case (state_q)
			S_CLEAR: begin
				tag_we    = 1'b1;
				tag_waddr = scan_addr_q[CAP_W-1:0];
			end
			S_UNL: begin
				tag_we    = 1'b1;
				old_we    = !s_new;
				old_waddr = n_q;
				old_wdata = (s_ext == nold) ? n_q : o_q;
				new_we    = !s_old;
				new_waddr = o_q;
				new_wdata = s_new ? o_q : n_q;
			end
			S_APP1: begin
				tag_we    = 1'b1;
				tag_wdata = item_tag;
				time_we   = 1'b1;
				old_we    = 1'b1;
				old_wdata = (newest_q == EMPTY_SLOT) ? tgt_q : newest_q[CAP_W-1:0];
				new_we    = 1'b1;
			end
			S_APP2: begin
				new_we    = newest_q != EMPTY_SLOT;
				new_waddr = newest_q[CAP_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign out_load = (state_q == S_OUT) && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			item_q <= fr_item;
		end
		if (state_q == S_EV) begin
			o_q     <= old_rd;
			n_q     <= new_rd;
			qtime_q <= time_rd;
		end
		if (out_load) begin
			out_has_q <= res_has_q;
			out_idx_q <= res_idx_q;
			out_max_q <= highest_q;
		end
		rd_addr_s1 <= scan_addr_q[CAP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			scan_addr_q <= '0;
			rd_vld_s1   <= 1'b0;
			match_vld_q <= 1'b0;
			match_q     <= '0;
			free_vld_q  <= 1'b0;
			free_q      <= '0;
			tgt_q       <= '0;
			do_app_q    <= 1'b0;
			do_bin_q    <= 1'b0;
			bin_go_q    <= 1'b0;
			res_has_q   <= 1'b0;
			res_idx_q   <= '0;
			oldest_q    <= EMPTY_SLOT;
			newest_q    <= EMPTY_SLOT;
			count_q     <= '0;
			highest_q   <= IDX_ERROR;
			out_vld_q   <= 1'b0;
		end else begin
			bin_go_q  <= 1'b0;
			rd_vld_s1 <= (state_q == S_SCAN) && (scan_addr_q != EMPTY_SLOT);
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					scan_addr_q <= scan_addr_q + 1'b1;
					if (scan_addr_q[CAP_W-1:0] == CAP_W'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (fr_vld) begin
						scan_addr_q <= '0;
						match_vld_q <= 1'b0;
						free_vld_q  <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_addr_q != EMPTY_SLOT) begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
					if (rd_vld_s1) begin
						if (hit && !match_vld_q) begin
							match_vld_q <= 1'b1;
							match_q     <= rd_addr_s1;
						end
						// lowest free slot wins
						if (!tag_rd.valid && !free_vld_q) begin
							free_vld_q <= 1'b1;
							free_q     <= rd_addr_s1;
						end
						if (rd_addr_s1 == CAP_W'(CAPACITY - 1)) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					tgt_q   <= rd_slot;
					state_q <= S_EV;
				end
				S_EV: begin
					do_app_q  <= 1'b0;
					do_bin_q  <= 1'b0;
					res_has_q <= 1'b1;
					res_idx_q <= IDX_TIMEOUT;
					state_q   <= S_OUT;
					if (item_q.is_response) begin
						if (match_vld_q) begin
							do_bin_q <= 1'b1;
							state_q  <= S_UNL;
						end else begin
							res_idx_q <= IDX_MISSING;
						end
					end else if (match_vld_q) begin
						do_app_q <= 1'b1;
						state_q  <= S_UNL;
					end else if (full) begin
						if (young) begin
							res_idx_q <= IDX_DROPPED;
						end
						if (!young || full_mode_q) begin
							do_app_q <= 1'b1;
							state_q  <= S_UNL;
						end
					end else if (free_vld_q) begin
						tgt_q     <= free_q;
						do_app_q  <= 1'b1;
						res_has_q <= 1'b0;
						state_q   <= S_APP1;
					end else begin
						res_idx_q <= IDX_ERROR;
					end
				end
				S_UNL: begin
					oldest_q <= nold;
					newest_q <= nnew;
					if (count_q != '0) begin
						count_q <= count_q - 1'b1;
					end
					if (do_app_q) begin
						state_q <= S_APP1;
					end else if (do_bin_q) begin
						bin_go_q <= 1'b1;
						state_q  <= S_BIN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_APP1: begin
					if (newest_q == EMPTY_SLOT) begin
						oldest_q <= {1'b0, tgt_q};
					end
					state_q <= S_APP2;
				end
				S_APP2: begin
					newest_q <= {1'b0, tgt_q};
					count_q  <= count_q + 1'b1;
					state_q  <= S_OUT;
				end
				S_BIN: begin
					if (bin_done) begin
						res_idx_q <= bin_idx;
						if ((bin_idx >= FIRST_BIN) && (bin_idx > highest_q)) begin
							highest_q <= bin_idx;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.has_index      = out_has_q;
	assign rsp.index          = out_idx_q;
	assign rsp.max_index_seen = out_max_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(CAPACITY))
		else $error("pending count above table size");

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((oldest_q == EMPTY_SLOT) == (newest_q == EMPTY_SLOT)))
		else $error("age list ends disagree on emptiness");

	a_highest_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 highest_q >= $past(highest_q))
		else $error("highest bin index fell");

endmodule
